// File: hw/rtl/gost_pkg.sv
package gost_pkg;

    localparam int ROUNDS    = 32;
    localparam int ROT_BITS  = 11;
    localparam int WORD_W    = 32;
    localparam int NIB_W     = 4;
    localparam int NIBBLES   = WORD_W / NIB_W;
    localparam int CNT_W     = $clog2(ROUNDS + 1);
    localparam int STAGE_W   = $clog2(ROUNDS);
    localparam int KEY_REGS  = 4;

    // Input item modes.
    localparam logic [1:0] MODE_ENC  = 2'd0;
    localparam logic [1:0] MODE_DEC  = 2'd1;
    localparam logic [1:0] MODE_LOAD = 2'd2;

    typedef logic [NIBBLES-1:0][63:0] sbox_t;
    typedef logic [KEY_REGS-1:0][63:0] keys_t;

    // Key schedule: encryption runs K0..K7 three times then K7..K0,
    // decryption runs K0..K7 once then K7..K0 three times.
    function automatic logic [2:0] key_idx(input logic [STAGE_W-1:0] rnd, input logic dec);
        logic fwd;
        begin
            fwd = dec ? (rnd < STAGE_W'(8)) : (rnd < STAGE_W'(24));
            key_idx = fwd ? rnd[2:0] : ~rnd[2:0];
        end
    endfunction

    function automatic logic [WORD_W-1:0] key_word(input keys_t keys, input logic [2:0] idx);
        logic [63:0] pair;
        begin
            pair     = keys[idx[2:1]];
            key_word = idx[0] ? pair[63:32] : pair[31:0];
        end
    endfunction

    // One round function: add key, substitute each nibble through its row,
    // rotate left.
    function automatic logic [WORD_W-1:0] round_f(input logic [WORD_W-1:0] n1,
                                                   input logic [WORD_W-1:0] k,
                                                   input sbox_t sbox);
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] sub;
        logic [NIB_W-1:0]  nib;
        begin
            sum = n1 + k;
            sub = '0;
            for (int i = 0; i < NIBBLES; i++)
            begin
                nib = sum[NIB_W*i +: NIB_W];
                sub[NIB_W*i +: NIB_W] = sbox[i][NIB_W*nib +: NIB_W];
            end
            round_f = (sub << ROT_BITS) | (sub >> (WORD_W - ROT_BITS));
        end
    endfunction

endpackage

// File: hw/rtl/gost_block_cipher_ecb.sv
// GOST 28147-89 block cipher in electronic codebook mode, built as a fully
// unrolled 32-stage pipeline with one Feistel round per register stage and an
// output register behind the last stage. An encrypt or decrypt transaction
// (mode 0 or 1) may be accepted in every cycle and its result leaves through
// the output register. When the output is not stalled, the sustained rate is
// one block per cycle, set by the per-stage round logic (one 32-bit add, the
// nibble substitution and the rotate). The input side keeps accepting while a
// finished result waits in the output register, as long as the last round
// stage is free. A row-load transaction (mode 2) writes one S-box row and
// produces no result; it is held off until no block is in flight in the round
// stages, so every block sees the table that was in place when it entered.
// Mode 3 is accepted and dropped. The user must write the four 64-bit key
// registers through the plain write port (cfg_we, cfg_index, cfg_data) only
// while the block is idle; the block itself does not enforce this. Indexes
// past the last register are ignored. S-box rows must be loaded before any
// block that uses them.
module gost_block_cipher_ecb
    import gost_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [63:0] block_in,
    input  logic [2:0]  row_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] block_out
);

    localparam int LAST = ROUNDS - 1;

    // Control state.
    logic [ROUNDS-1:0] vld_reg;
    logic              out_valid_reg;
    logic [CNT_W-1:0]  inflight_reg;
    keys_t             keys_reg;

    // Payload state.
    logic [WORD_W-1:0] n1_reg [ROUNDS];
    logic [WORD_W-1:0] n2_reg [ROUNDS];
    logic [ROUNDS-1:0] dec_reg;
    sbox_t             sbox_rows_reg;
    logic [63:0]       block_out_reg;

    // Round inputs and outputs for each stage.
    logic [WORD_W-1:0] src_n1 [ROUNDS];
    logic [WORD_W-1:0] src_n2 [ROUNDS];
    logic [ROUNDS-1:0] src_dec;
    logic [WORD_W-1:0] n1_next [ROUNDS];
    logic [WORD_W-1:0] n2_next [ROUNDS];

    logic              cipher_in;
    logic              load_in;
    logic              adv;
    logic              in_acc;
    logic              enter;
    logic              leave;
    logic              out_load;

    // The pipeline moves as one; it only has to hold when the last stage is
    // full and the output register cannot take it.
    always_comb
    begin
        cipher_in = (mode == MODE_ENC) || (mode == MODE_DEC);
        load_in   = (mode == MODE_LOAD);
        adv       = !vld_reg[LAST] || !out_valid_reg || out_ready;
        in_ready  = adv && (!load_in || (inflight_reg == '0));
        in_acc    = in_valid && in_ready;
        enter     = in_acc && cipher_in;
        leave     = adv && vld_reg[LAST];
        out_load  = !out_valid_reg || out_ready;
    end

    // The first round works straight on the incoming block; every other
    // round works on the stage register before it.
    always_comb
    begin
        src_n1[0]  = block_in[63:32];
        src_n2[0]  = block_in[31:0];
        src_dec[0] = (mode == MODE_DEC);
        for (int r = 1; r < ROUNDS; r++)
        begin
            src_n1[r]  = n1_reg[r-1];
            src_n2[r]  = n2_reg[r-1];
            src_dec[r] = dec_reg[r-1];
        end
    end

    always_comb
    begin
        logic [WORD_W-1:0] s;
        for (int r = 0; r < ROUNDS; r++)
        begin
            s = src_n2[r] ^ round_f(src_n1[r],
                                    key_word(keys_reg, key_idx(STAGE_W'(r), src_dec[r])),
                                    sbox_rows_reg);
            if (r == LAST)
            begin
                // The final round leaves N1 in place and writes only N2.
                n1_next[r] = src_n1[r];
                n2_next[r] = s;
            end
            else
            begin
                n1_next[r] = s;
                n2_next[r] = src_n1[r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            inflight_reg  <= '0;
            keys_reg      <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index < 3'(KEY_REGS)))
            begin
                keys_reg[cfg_index[1:0]] <= cfg_data;
            end
            if (adv)
            begin
                vld_reg <= {vld_reg[ROUNDS-2:0], enter};
            end
            if (out_load)
            begin
                out_valid_reg <= vld_reg[LAST];
            end
            if (enter && !leave)
            begin
                inflight_reg <= inflight_reg + CNT_W'(1);
            end
            else if (leave && !enter)
            begin
                inflight_reg <= inflight_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && load_in)
        begin
            sbox_rows_reg[row_index] <= block_in;
        end
        if (adv)
        begin
            for (int r = 0; r < ROUNDS; r++)
            begin
                n1_reg[r]  <= n1_next[r];
                n2_reg[r]  <= n2_next[r];
                dec_reg[r] <= src_dec[r];
            end
        end
        if (out_load)
        begin
            block_out_reg <= {n1_reg[LAST], n2_reg[LAST]};
        end
    end

    assign out_valid = out_valid_reg;
    assign block_out = block_out_reg;

    // A row load is only taken with the round stages empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (mode == MODE_LOAD)) |-> (vld_reg == '0))
        else $error("S-box row written while blocks are in flight");

    // The in-flight count tracks the stage valid bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(vld_reg) == 32'(inflight_reg))
        else $error("in-flight count out of step with stage valid bits");

    // A block leaving the last round stage lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && vld_reg[LAST]) |=> out_valid_reg)
        else $error("block lost between last round and output register");

    // A waiting result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(block_out_reg)))
        else $error("pending result changed before it was taken");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking testbench for the GOST 28147-89 ECB cipher pipeline.
// A short table of directed transactions comes first. Its first part runs
// with all S-box rows zero, so the round function is zero and a block only
// has its halves swapped. The random phases that follow run under several key
// settings and idling profiles. Each block is checked against a value typed in
// by hand or against a local model of the cipher.
module tb_top;
    import gost_pkg::*;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam logic [2:0] REG_KEY01     = 3'd0;
    localparam logic [2:0] REG_KEY23     = 3'd1;
    localparam logic [2:0] REG_KEY45     = 3'd2;
    localparam logic [2:0] REG_KEY67     = 3'd3;
    localparam logic [2:0] REG_UNUSED_LO = 3'd4;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;

    localparam int DRAIN_CYCLES    = ROUNDS + 8;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int DIR_ROWS        = 19;

    // One row of the directed table. When known is set, want is the block
    // that the row must produce, typed in by hand.
    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] data;
        logic [2:0]  row;
        logic        known;
        logic [63:0] want;
    } dir_vector_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [63:0] block_in;
    logic [2:0]  row_index;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] block_out;

    // The cipher model keeps its own copy of the keys and the substitution
    // table, and it is updated at the edge where a transaction is accepted.
    logic [63:0] key_pairs [KEY_REGS];
    logic [63:0] subst_table [NIBBLES];
    logic [63:0] expected_blocks [$];

    int send_idle_pct = 36;
    int recv_idle_pct = 59;
    bit hold_off_req  = 1'b0;
    int err_cnt       = 0;
    int results_seen  = 0;
    int enc_cnt       = 0;
    int dec_cnt       = 0;
    int load_cnt      = 0;
    int drop_cnt      = 0;
    int key_sets      = 0;
    int stall_cycles  = 0;

    gost_block_cipher_ecb u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .block_in  (block_in),
        .row_index (row_index),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .block_out (block_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Key schedule. Encryption walks K0..K7 three times and then K7..K0.
    // Decryption walks K0..K7 once and then K7..K0 three times.
    function automatic logic [2:0] round_key_sel(input int rnd, input bit decrypt);
        if (decrypt)
            return (rnd < 8) ? 3'(rnd) : 3'(7 - (rnd % 8));
        return (rnd < 24) ? 3'(rnd % 8) : 3'(7 - (rnd % 8));
    endfunction

    // Round function: add the key word mod 2^32, send each nibble through
    // its own S-box row, then rotate left.
    function automatic logic [31:0] feistel_f(input logic [31:0] half, input logic [31:0] kw);
        logic [31:0] sum;
        logic [31:0] sub;
        logic [3:0]  nib;
        sum = half + kw;
        sub = '0;
        for (int i = 0; i < NIBBLES; i++)
        begin
            nib = sum[4*i +: 4];
            sub[4*i +: 4] = subst_table[i][4*nib +: 4];
        end
        return (sub << ROT_BITS) | (sub >> (WORD_W - ROT_BITS));
    endfunction

    // Full 32-round block transform. N1 is the upper word. The last round
    // writes N2 only and leaves N1 in place.
    function automatic logic [63:0] gost_crypt(input logic [63:0] blk, input bit decrypt);
        logic [31:0] n1;
        logic [31:0] n2;
        logic [31:0] s;
        logic [31:0] kw;
        logic [2:0]  ki;
        n1 = blk[63:32];
        n2 = blk[31:0];
        for (int r = 0; r < ROUNDS; r++)
        begin
            ki = round_key_sel(r, decrypt);
            kw = ki[0] ? key_pairs[ki[2:1]][63:32] : key_pairs[ki[2:1]][31:0];
            s  = n2 ^ feistel_f(n1, kw);
            if (r == ROUNDS - 1)
                n2 = s;
            else
            begin
                n2 = n1;
                n1 = s;
            end
        end
        return {n1, n2};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
        err_cnt++;
    endtask

    // Offers one input transaction, after a random idle gap, and holds it
    // until it is accepted. Then the model is updated. valid is lowered
    // only when a gap is actually taken, so it never drops and rises
    // again within the same time step.
    task automatic send_item(input logic [1:0] op, input logic [63:0] data,
                             input logic [2:0] row, input logic known,
                             input logic [63:0] want);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= op;
        block_in  <= data;
        row_index <= row;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (op)
            MODE_ENC:
            begin
                expected_blocks.push_back(known ? want : gost_crypt(data, 1'b0));
                enc_cnt++;
            end
            MODE_DEC:
            begin
                expected_blocks.push_back(known ? want : gost_crypt(data, 1'b1));
                dec_cnt++;
            end
            MODE_LOAD:
            begin
                subst_table[row] = data;
                load_cnt++;
            end
            default:
                drop_cnt++;
        endcase
    endtask

    // Brings the block to idle before the configuration changes. First
    // every pending block must come out, then a drain wait follows.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx < KEY_REGS)
            key_pairs[idx] = val;
    endtask

    // Writes all four key registers in back-to-back cycles. The write
    // enable stays high, so the caller lowers it once the group is done.
    task automatic set_keys(input logic [63:0] k01, input logic [63:0] k23,
                            input logic [63:0] k45, input logic [63:0] k67);
        write_reg(REG_KEY01, k01);
        write_reg(REG_KEY23, k23);
        write_reg(REG_KEY45, k45);
        write_reg(REG_KEY67, k67);
        key_sets++;
    endtask

    // Random traffic. Most transactions are encrypt or decrypt blocks. Row
    // loads with random content are mixed in, so the table keeps changing between
    // blocks. A few mode-3 transactions are dropped by the block, and they are
    // not counted toward the requested number.
    task automatic run_random(input int count);
        int          done;
        int          pick;
        logic [63:0] data;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            case ($urandom_range(9))
                0:       data = '0;
                1:       data = '1;
                2:       data = {2{32'hAAAA_5555}};
                default: data = {$urandom, $urandom};
            endcase
            if (pick < 45)
                send_item(MODE_ENC, data, 3'($urandom_range(7)), 1'b0, '0);
            else if (pick < 90)
                send_item(MODE_DEC, data, 3'($urandom_range(7)), 1'b0, '0);
            else if (pick < 96)
                send_item(MODE_LOAD, {$urandom, $urandom}, 3'($urandom_range(7)), 1'b0, '0);
            else
                send_item(MODE_UNUSED, data, 3'($urandom_range(7)), 1'b0, '0);
            if (pick < 96)
                done++;
        end
    endtask

    // Result checker. Each accepted output transaction is compared with the
    // oldest block that is still expected.
    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_blocks.size() == 0)
                report_mismatch("unexpected result", block_out, '0);
            else
            begin
                want = expected_blocks.pop_front();
                if (block_out !== want)
                    report_mismatch("block_out", block_out, want);
                results_seen++;
            end
        end
    end

    // Receiver. It is ready at random as its idle rate allows. Once the
    // main sequence asks for it, there is one long hold-off so that the
    // pipeline fills up and stalls the input side.
    initial
    begin
        int hold;
        bit hold_taken;
        hold       = 0;
        hold_taken = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold       = HOLD_OFF_CYCLES;
            end
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run if neither channel moves a transaction for
    // too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        dir_vector_t directed_vectors [DIR_ROWS];

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        mode      <= MODE_ENC;
        block_in  <= '0;
        row_index <= '0;
        foreach (key_pairs[i])
            key_pairs[i] = '0;
        foreach (subst_table[i])
            subst_table[i] = '0;

        // With every S-box row zero, the round function is zero. Every round
        // but the last swaps the halves, so a block comes out with its two
        // words swapped whatever the key. A mode-3 transaction with row 7 and
        // all ones must not disturb this. The last rows load two real rows
        // and are checked against the model.
        directed_vectors = '{
            '{MODE_LOAD,   64'h0,                   3'd0, 1'b0, 64'h0},
            '{MODE_LOAD,   64'h0,                   3'd1, 1'b0, 64'h0},
            '{MODE_LOAD,   64'h0,                   3'd2, 1'b0, 64'h0},
            '{MODE_LOAD,   64'h0,                   3'd3, 1'b0, 64'h0},
            '{MODE_LOAD,   64'h0,                   3'd4, 1'b0, 64'h0},
            '{MODE_LOAD,   64'h0,                   3'd5, 1'b0, 64'h0},
            '{MODE_LOAD,   64'h0,                   3'd6, 1'b0, 64'h0},
            '{MODE_LOAD,   64'h0,                   3'd7, 1'b0, 64'h0},
            '{MODE_ENC,    64'h0,                   3'd0, 1'b1, 64'h0},
            '{MODE_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 1'b0, 64'h0},
            '{MODE_ENC,    64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
            '{MODE_DEC,    64'h0123_4567_89AB_CDEF, 3'd0, 1'b1, 64'h89AB_CDEF_0123_4567},
            '{MODE_DEC,    64'hFEDC_BA98_7654_3210, 3'd0, 1'b1, 64'h7654_3210_FEDC_BA98},
            '{MODE_ENC,    64'hDEAD_BEEF_0000_0001, 3'd0, 1'b1, 64'h0000_0001_DEAD_BEEF},
            '{MODE_LOAD,   64'hFEDC_BA98_7654_3210, 3'd0, 1'b0, 64'h0},
            '{MODE_LOAD,   64'h0F1E_2D3C_4B5A_6978, 3'd7, 1'b0, 64'h0},
            '{MODE_ENC,    64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 1'b0, 64'h0},
            '{MODE_DEC,    64'h0,                   3'd0, 1'b0, 64'h0},
            '{MODE_ENC,    64'h0123_4567_89AB_CDEF, 3'd0, 1'b0, 64'h0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // The directed part runs on the reset keys. The sender idles 36%
        // and the receiver 59%.
        foreach (directed_vectors[i])
            send_item(directed_vectors[i].op, directed_vectors[i].data,
                      directed_vectors[i].row, directed_vectors[i].known,
                      directed_vectors[i].want);

        // All-ones keys exercise the carry out of the key addition.
        wait_drained();
        set_keys('1, '1, '1, '1);
        cfg_we <= 1'b0;
        run_random(ITEMS_PER_PHASE);

        wait_drained();
        set_keys({$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        cfg_we <= 1'b0;
        run_random(ITEMS_PER_PHASE);

        // The idle rates are swapped here. Writes to the indexes past the
        // last key register must be ignored.
        wait_drained();
        send_idle_pct = 59;
        recv_idle_pct = 36;
        set_keys({$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        write_reg(REG_UNUSED_LO, {$urandom, $urandom});
        write_reg(REG_UNUSED_HI, '1);
        cfg_we <= 1'b0;
        run_random(ITEMS_PER_PHASE);

        wait_drained();
        set_keys({4{16'hAAAA}}, {4{16'h5555}},
                 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000);
        cfg_we <= 1'b0;
        run_random(ITEMS_PER_PHASE);

        // The last phase has no idling and zero keys. The receiver holds
        // off once for a long stretch while the sender keeps offering.
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_keys('0, '0, '0, '0);
        cfg_we <= 1'b0;
        hold_off_req = 1'b1;
        run_random(ITEMS_PER_PHASE);

        wait_drained();

        $display("Covered %0d encryptions, %0d decryptions, %0d S-box row loads and %0d dropped",
                 enc_cnt, dec_cnt, load_cnt, drop_cnt);
        $display("mode-3 transactions under %0d key settings; %0d results compared, %0d mismatches.",
                 key_sets + 1, results_seen, err_cnt);
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
